// ===== hdl/tafir_pkg.sv =====
// Shared types and constants for the three-axis FIR filter.
`default_nettype none

package tafir_pkg;

  localparam int COEF_BITS     = 16;
  localparam int COEF_SLOTS    = 64;
  localparam int COEF_IDX_BITS = 6;
  localparam int OUT_BITS      = 24;
  localparam int ACC_SHIFT     = 7;
  localparam int GUARD_BITS    = 6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Q1.15 taps; slots past the designed length are zero.
  localparam logic signed [COEF_BITS-1:0] COEF [COEF_SLOTS] = '{
    16'sd152,   16'sd242,   -16'sd79,   -16'sd233,  16'sd107,   16'sd2,     -16'sd307,  16'sd130,
    16'sd143,   -16'sd436,  16'sd100,   16'sd375,   -16'sd587,  -16'sd35,   16'sd729,   -16'sd737,
    -16'sd356,  16'sd1298,  -16'sd863,  -16'sd1106, 16'sd2464,  -16'sd947,  -16'sd3944, 16'sd9435,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
    16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0
  };

  typedef struct packed {
    logic                     shift_in;
    logic                     mul_en;
    logic [1:0]               axis;
    logic [COEF_IDX_BITS-1:0] tap;
    logic                     first;
    logic                     last;
    logic                     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/tafir_ctrl.sv =====
// Sequencer that steps the shared multiplier over all taps of each axis.
`default_nettype none

module tafir_ctrl #(
  parameter int TAPS = 24
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire tafir_pkg::dp_status_t status,
  output tafir_pkg::dp_cmd_t        cmd
);

  localparam int TAP_BITS = (TAPS > 1) ? $clog2(TAPS) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_MAC   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_PUSH  = 4'b1000
  } state_t;

  state_t              state, state_next;
  logic [TAP_BITS-1:0] tap, tap_next;
  logic [1:0]          axis, axis_next;
  logic                accept;
  logic                tap_end;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign tap_end  = (tap == TAP_BITS'(TAPS - 1));

  always_comb begin
    state_next   = state;
    tap_next     = tap;
    axis_next    = axis;
    cmd          = '0;
    cmd.axis     = axis;
    cmd.tap      = tafir_pkg::COEF_IDX_BITS'(tap);
    cmd.first    = (tap == '0);
    cmd.last     = tap_end;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.shift_in = 1'b1;
          tap_next     = '0;
          axis_next    = tafir_pkg::AXIS_X;
          state_next   = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mul_en = 1'b1;
        if (tap_end) begin
          tap_next = '0;
          if (axis == tafir_pkg::AXIS_Z) begin
            state_next = S_FLUSH;
          end else begin
            axis_next = axis + 2'd1;
          end
        end else begin
          tap_next = tap + TAP_BITS'(1);
        end
      end
      S_FLUSH: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        // hold the results until the output register can take them
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tap   <= '0;
      axis  <= tafir_pkg::AXIS_X;
    end else begin
      state <= state_next;
      tap   <= tap_next;
      axis  <= axis_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_MAC && tap == '0 && axis == tafir_pkg::AXIS_X)
    else $error("accepted request did not start the tap sweep");
  a_push_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && status.out_free) |=> state == S_IDLE)
    else $error("result push did not release the input");
`endif

endmodule

`default_nettype wire

// ===== hdl/tafir_dp.sv =====
// Delay lines, shared multiply-accumulate and output register of the filter.
`default_nettype none

module tafir_dp #(
  parameter int TAPS        = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire        [SAMPLE_BITS-1:0]            sample_x,
  input  wire        [SAMPLE_BITS-1:0]            sample_y,
  input  wire        [SAMPLE_BITS-1:0]            sample_z,
  output logic signed [tafir_pkg::OUT_BITS-1:0]   filtered_x,
  output logic signed [tafir_pkg::OUT_BITS-1:0]   filtered_y,
  output logic signed [tafir_pkg::OUT_BITS-1:0]   filtered_z,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  input  wire tafir_pkg::dp_cmd_t                 cmd,
  output tafir_pkg::dp_status_t                   status
);

  localparam int PROD_BITS = SAMPLE_BITS + tafir_pkg::COEF_BITS;
  localparam int ACC_BITS  = PROD_BITS + tafir_pkg::GUARD_BITS;
  localparam int Q_BITS    = ACC_BITS - tafir_pkg::ACC_SHIFT;
  localparam int OB        = tafir_pkg::OUT_BITS;

  logic signed [SAMPLE_BITS-1:0] line [3][TAPS];
  logic signed [SAMPLE_BITS-1:0] in_word [3];
  logic signed [SAMPLE_BITS-1:0] head;
  logic signed [tafir_pkg::COEF_BITS-1:0] coef;

  logic signed [PROD_BITS-1:0] prod;
  logic                        p_valid;
  logic                        p_first;
  logic                        p_last;
  logic [1:0]                  p_axis;

  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS-1:0]  acc_next;
  logic signed [Q_BITS-1:0]    q;
  logic signed [63:0]          q_wide;
  logic signed [OB-1:0]        sat;
  logic signed [OB-1:0]        res [3];

  assign in_word[0] = sample_x;
  assign in_word[1] = sample_y;
  assign in_word[2] = sample_z;

  assign status.out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (cmd.axis)
      tafir_pkg::AXIS_X: head = line[0][0];
      tafir_pkg::AXIS_Y: head = line[1][0];
      tafir_pkg::AXIS_Z: head = line[2][0];
      default:           head = '0;
    endcase
  end

  assign coef = tafir_pkg::COEF[cmd.tap];

  // Shift in the new sample; while sweeping, rotate the active line so that
  // its head walks through every tap and the line ends where it started.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < TAPS; i++) begin
          line[a][i] <= '0;
        end
      end
    end else if (cmd.shift_in) begin
      for (int a = 0; a < 3; a++) begin
        line[a][0] <= in_word[a];
        for (int i = 1; i < TAPS; i++) begin
          line[a][i] <= line[a][i-1];
        end
      end
    end else if (cmd.mul_en) begin
      for (int a = 0; a < 3; a++) begin
        if (cmd.axis == 2'(a)) begin
          for (int i = 0; i < TAPS - 1; i++) begin
            line[a][i] <= line[a][i+1];
          end
          line[a][TAPS-1] <= line[a][0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod   <= head * coef;
    p_first <= cmd.first;
    p_axis  <= cmd.axis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      p_last  <= 1'b0;
    end else begin
      p_valid <= cmd.mul_en;
      p_last  <= cmd.mul_en && cmd.last;
    end
  end

  assign acc_next = p_first ? ACC_BITS'(prod) : acc + ACC_BITS'(prod);
  // arithmetic shift floors, then clamp to the output range
  assign q        = Q_BITS'(acc_next >>> tafir_pkg::ACC_SHIFT);
  assign q_wide   = 64'(q);

  always_comb begin
    priority if (q_wide > 64'sd8388607) begin
      sat = {1'b0, {(OB-1){1'b1}}};
    end else if (q_wide < -64'sd8388608) begin
      sat = {1'b1, {(OB-1){1'b0}}};
    end else begin
      sat = q_wide[OB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid) begin
      acc <= acc_next;
    end
    if (p_last) begin
      res[p_axis] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      filtered_x <= res[0];
      filtered_y <= res[1];
      filtered_z <= res[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register loaded while holding an untaken request");
  a_shift_idle_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_in |-> !cmd.mul_en && !p_valid)
    else $error("sample shifted in during a tap sweep");
`endif

endmodule

`default_nettype wire

// ===== hdl/three_axis_fir_filter_core.sv =====
// Top level of the three-axis FIR filter: sequencer plus datapath.
//
// Usage:
//   Input channel: sample_x/y/z with in_valid; the block raises in_stall
//   while it works. A request is taken on a clock edge with in_valid high
//   and in_stall low.
//   Output channel: filtered_x/y/z (8 fraction bits, saturated) with
//   out_valid; the receiver drives out_stall. A result is taken on an edge
//   with out_valid high and out_stall low.
//   One multiplier serves all taps of all three axes, one tap per cycle;
//   a new request is taken only once the results of the previous one are
//   loaded into the output register (in_stall stays high until then).
//   A held result stays in the output register while the next request is
//   swept; if it is still held when that sweep ends, the block waits with
//   in_stall high until the receiver takes it.
//   Reset (rst, synchronous) clears all delay lines to zero and empties the
//   output register.
`default_nettype none

module three_axis_fir_filter_core #(
  parameter int TAPS        = 24,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire        [SAMPLE_BITS-1:0]          sample_x,
  input  wire        [SAMPLE_BITS-1:0]          sample_y,
  input  wire        [SAMPLE_BITS-1:0]          sample_z,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  output logic signed [tafir_pkg::OUT_BITS-1:0] filtered_x,
  output logic signed [tafir_pkg::OUT_BITS-1:0] filtered_y,
  output logic signed [tafir_pkg::OUT_BITS-1:0] filtered_z,
  output logic                                  out_valid,
  input  wire                                   out_stall
);

  tafir_pkg::dp_cmd_t    cmd;
  tafir_pkg::dp_status_t status;

  tafir_ctrl #(
    .TAPS (TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tafir_dp #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .sample_x   (sample_x),
    .sample_y   (sample_y),
    .sample_z   (sample_z),
    .filtered_x (filtered_x),
    .filtered_y (filtered_y),
    .filtered_z (filtered_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status)
  );

endmodule

`default_nettype wire

// ===== bench/three_axis_fir_filter_core_tb.sv =====
// Self-checking testbench for the three-axis FIR filter core.
`default_nettype none

module three_axis_fir_filter_core_tb;

  localparam int CLK_PERIOD       = 20;
  localparam int NUM_TAPS         = 24;
  localparam int SAMPLE_W         = 16;
  localparam int OUT_W            = tafir_pkg::OUT_BITS;
  localparam int RANDOM_ITEMS     = 900;
  localparam int NUM_PHASES       = 4;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 100;
  localparam longint WATCHDOG_CYCLES = 1000000;
  localparam longint SAT_HI = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< (OUT_W - 1));

  // Q1.15 taps, position 0 applies to the newest sample
  localparam int TAP_COEF [NUM_TAPS] = '{
    152, 242, -79, -233, 107, 2, -307, 130,
    143, -436, 100, 375, -587, -35, 729, -737,
    -356, 1298, -863, -1106, 2464, -947, -3944, 9435
  };

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_EDGE} mix_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } filt_triple_t;

  typedef struct {
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    bit                  fixed;
    filt_triple_t        want;
  } stim_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic [SAMPLE_W-1:0]        sample_x = '0;
  logic [SAMPLE_W-1:0]        sample_y = '0;
  logic [SAMPLE_W-1:0]        sample_z = '0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [OUT_W-1:0]    filtered_x;
  logic signed [OUT_W-1:0]    filtered_y;
  logic signed [OUT_W-1:0]    filtered_z;
  logic                       out_valid;
  logic                       out_stall = 1'b0;

  logic signed [SAMPLE_W-1:0] tap_line [3][NUM_TAPS];
  filt_triple_t               pending_results[$];
  stim_row_t                  dir_rows[$];
  filt_triple_t               oldest_result;
  int                         error_count = 0;
  int                         idle_pct = 0;
  int                         stall_pct = 0;
  bit                         hold_request = 1'b0;
  int                         hold_left = 0;

  three_axis_fir_filter_core DUT (
    .clk       (clk),
    .rst       (rst),
    .sample_x  (sample_x),
    .sample_y  (sample_y),
    .sample_z  (sample_z),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .filtered_x(filtered_x),
    .filtered_y(filtered_y),
    .filtered_z(filtered_z),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * WATCHDOG_CYCLES);
    $display("RESULT: ERROR");
    $finish;
  end

  // Shift one sample into an axis line and form the floored, saturated sum.
  function automatic logic signed [OUT_W-1:0] filter_axis(input int ax,
                                                          input logic signed [SAMPLE_W-1:0] s);
    longint acc;
    longint q;
    int i;
    acc = 0;
    for (i = NUM_TAPS - 1; i > 0; i--) tap_line[ax][i] = tap_line[ax][i-1];
    tap_line[ax][0] = s;
    for (i = 0; i < NUM_TAPS; i++) acc += longint'(tap_line[ax][i]) * longint'(TAP_COEF[i]);
    q = acc >>> tafir_pkg::ACC_SHIFT;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[OUT_W-1:0];
  endfunction

  function automatic void add_row(input logic [SAMPLE_W-1:0] x, y, z, input bit fixed = 1'b0,
                                  input int ex = 0, input int ey = 0, input int ez = 0);
    stim_row_t row;
    row.x = x;
    row.y = y;
    row.z = z;
    row.fixed = fixed;
    row.want.x = OUT_W'(ex);
    row.want.y = OUT_W'(ey);
    row.want.z = OUT_W'(ez);
    dir_rows.push_back(row);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample(input mix_t mode);
    logic [31:0] r;
    case (mode)
      MIX_SMALL: begin
        r = $urandom_range(32) - 16;
        return r[SAMPLE_W-1:0];
      end
      MIX_EDGE: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: begin
        r = $urandom;
        return r[SAMPLE_W-1:0];
      end
    endcase
  endfunction

  // Offer one request; valid stays high across back-to-back requests.
  task automatic offer(input stim_row_t row);
    filt_triple_t pred;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    sample_x <= row.x;
    sample_y <= row.y;
    sample_z <= row.z;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid === 1'b1 && in_stall === 1'b0));
    pred.x = filter_axis(int'(tafir_pkg::AXIS_X), $signed(row.x));
    pred.y = filter_axis(int'(tafir_pkg::AXIS_Y), $signed(row.y));
    pred.z = filter_axis(int'(tafir_pkg::AXIS_Z), $signed(row.z));
    if (row.fixed) pred = row.want;
    pending_results.push_back(pred);
  endtask

  task automatic check_axis(input string axis_name, input logic signed [OUT_W-1:0] want,
                            input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, axis_name, want, got);
    end
  endtask

  // Receiver: check taken results, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: expected nothing, got %0d %0d %0d",
                 $time, filtered_x, filtered_y, filtered_z);
      end else begin
        oldest_result = pending_results.pop_front();
        check_axis("filtered_x", oldest_result.x, filtered_x);
        check_axis("filtered_y", oldest_result.y, filtered_y);
        check_axis("filtered_z", oldest_result.z, filtered_z);
      end
    end
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    int ph;
    int sent;
    int k;
    int pick;
    mix_t mode;
    stim_row_t row;

    foreach (tap_line[a, t]) tap_line[a][t] = '0;

    // zero in gives zero out from a cleared line
    add_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 0, 0, 0);
    // unit impulse: a negative sum floors away from zero
    add_row(16'h0001, 16'hFFFF, 16'h0000, 1'b1, 1, -2, 0);
    add_row(16'h7FFF, 16'h8000, 16'hFFFF);
    add_row(16'h8000, 16'h7FFF, 16'h5555);
    add_row(16'h5555, 16'hAAAA, 16'h0001);
    // line up full-scale signs with the taps to push the sum toward its peak
    for (k = 19; k >= 0; k--)
      add_row((TAP_COEF[k] >= 0) ? 16'h7FFF : 16'h8000,
              (TAP_COEF[k] >= 0) ? 16'h8000 : 16'h7FFF,
              k[0] ? 16'h5555 : 16'hAAAA);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) offer(dir_rows[i]);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          hold_request = 1'b1;
        end
        1: begin
          idle_pct = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 76;
        end
        default: begin
          idle_pct = 20;
          stall_pct = 20;
        end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / NUM_PHASES) begin
        pick = $urandom_range(99);
        row.fixed = 1'b0;
        if (pick < 90) begin
          mode = (pick < 60) ? MIX_FULL : (pick < 75) ? MIX_SMALL : MIX_EDGE;
          row.x = rand_sample(mode);
          row.y = rand_sample(mode);
          row.z = rand_sample(mode);
          offer(row);
          sent++;
        end else begin
          // fill whole x and y lines with samples matched to the tap signs
          for (k = NUM_TAPS - 1; k >= 0; k--) begin
            row.x = (TAP_COEF[k] >= 0) ? 16'h7FFF : 16'h8000;
            row.y = (TAP_COEF[k] >= 0) ? 16'h8000 : 16'h7FFF;
            row.z = rand_sample(MIX_FULL);
            offer(row);
            sent++;
          end
        end
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
